>>> sv/hsvb_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hsvb_pkg
// Shared types, constants and lookup tables for the HSV to RGB converter
// with a brightness floor. All fractions are unsigned Q16 (1.0 = 65536).
// ---------------------------------------------------------------------------
package hsvb_pkg;

    // Fixed point format
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned Q_W       = FRAC_BITS + 1;

    typedef logic [Q_W-1:0]       q17_t;
    typedef logic [FRAC_BITS-1:0] frac_t;

    localparam q17_t ONE_Q  = q17_t'(1 << FRAC_BITS);
    localparam int unsigned HALF_Q = 1 << (FRAC_BITS - 1);

    // Input field widths
    localparam int unsigned HUE_W = 9;
    localparam int unsigned PCT_W = 7;
    localparam int unsigned CHAN_W = 8;

    // Range constants
    localparam int unsigned BRI_FLOOR   = 30;
    localparam int unsigned PCT_FULL    = 100;
    localparam int unsigned BRI_SPAN    = PCT_FULL + BRI_FLOOR;
    localparam int unsigned SECTOR_DEG  = 60;
    localparam int unsigned HUE_LIMIT   = 360;
    localparam int unsigned CHAN_MAX    = 255;
    localparam int unsigned NUM_SECT_TH = 8;

    // Sector and remainder widths (hue up to 511 gives sectors 0..8)
    localparam int unsigned SECT_W = 4;
    localparam int unsigned REM_W  = 6;
    localparam int unsigned FRAC_LUT_DEPTH = 1 << REM_W;
    localparam int unsigned PCT_LUT_DEPTH  = 1 << PCT_W;

    // Sector codes: each 60-degree slice of the color wheel
    localparam logic [SECT_W-1:0] SEC_RED_YEL = 4'd0;
    localparam logic [SECT_W-1:0] SEC_YEL_GRN = 4'd1;
    localparam logic [SECT_W-1:0] SEC_GRN_CYN = 4'd2;
    localparam logic [SECT_W-1:0] SEC_CYN_BLU = 4'd3;
    localparam logic [SECT_W-1:0] SEC_BLU_MAG = 4'd4;

    // Cycles from the accepting edge to the edge that takes the result
    localparam int unsigned LATENCY = 5;

    // Request and result payloads
    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] saturation;
        logic [PCT_W-1:0] brightness;
    } req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              color_valid;
    } rsp_t;

    typedef q17_t  pct_lut_t  [PCT_LUT_DEPTH];
    typedef frac_t frac_lut_t [FRAC_LUT_DEPTH];

    // Value table: floor((brightness + 30) * 65536 / 130)
    function automatic pct_lut_t make_v_lut();
        pct_lut_t lut;
        for (int i = 0; i < PCT_LUT_DEPTH; i++)
        begin
            lut[i] = q17_t'(((i + BRI_FLOOR) << FRAC_BITS) / BRI_SPAN);
        end
        return lut;
    endfunction

    // Saturation table: floor(saturation * 65536 / 100)
    function automatic pct_lut_t make_s_lut();
        pct_lut_t lut;
        for (int i = 0; i < PCT_LUT_DEPTH; i++)
        begin
            lut[i] = q17_t'((i << FRAC_BITS) / PCT_FULL);
        end
        return lut;
    endfunction

    // Hue fraction table: floor(rem * 65536 / 60), unused codes read zero
    function automatic frac_lut_t make_f_lut();
        frac_lut_t lut;
        for (int i = 0; i < FRAC_LUT_DEPTH; i++)
        begin
            if (i < SECTOR_DEG)
            begin
                lut[i] = frac_t'((i << FRAC_BITS) / SECTOR_DEG);
            end
            else
            begin
                lut[i] = '0;
            end
        end
        return lut;
    endfunction

    localparam pct_lut_t  V_LUT = make_v_lut();
    localparam pct_lut_t  S_LUT = make_s_lut();
    localparam frac_lut_t F_LUT = make_f_lut();

    // 1 - x, held at zero
    function automatic q17_t one_minus(input q17_t x);
        return (x >= ONE_Q) ? '0 : q17_t'(ONE_Q - x);
    endfunction

    // Sector number: count of 60-degree thresholds at or below hue
    function automatic logic [SECT_W-1:0] hue_sector(input logic [HUE_W-1:0] hue);
        logic [SECT_W-1:0] sec;
        sec = '0;
        for (int i = 1; i <= NUM_SECT_TH; i++)
        begin
            if (hue >= HUE_W'(i * SECTOR_DEG))
            begin
                sec = sec + 1'b1;
            end
        end
        return sec;
    endfunction

endpackage
`default_nettype wire

>>> sv/hsvb_shade.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hsvb_shade
// One registered shade product: floor(v * (1 - x) / 65536), with 1 - x
// held at zero. Used for the p, q and t terms.
// ---------------------------------------------------------------------------
module hsvb_shade (
    input  wire logic          clk,
    input  wire hsvb_pkg::q17_t v,
    input  wire hsvb_pkg::q17_t x,
    output hsvb_pkg::q17_t      shade
);

    localparam int unsigned PROD_W = 2 * hsvb_pkg::Q_W;

    hsvb_pkg::q17_t      factor;
    logic [PROD_W-1:0]   prod;
    hsvb_pkg::q17_t      shade_next;
    hsvb_pkg::q17_t      shade_reg;

    // Form the complement and scale by value
    always_comb
    begin
        factor     = hsvb_pkg::one_minus(x);
        prod       = PROD_W'(v) * PROD_W'(factor);
        shade_next = prod[hsvb_pkg::FRAC_BITS +: hsvb_pkg::Q_W];
    end

    // Hold the product for the next stage
    always_ff @(posedge clk)
    begin
        shade_reg <= shade_next;
    end

    assign shade = shade_reg;

endmodule
`default_nettype wire

>>> sv/hsv_to_rgb_with_brightness_floor_core.sv
`default_nettype none
// Pipeline: a request taken at a rising edge shows its result on the result
//   ports, with done high, after passing through five register stages in all.
// Throughput: one request per clock; busy is always low.
// Each stage holds at most one multiplier row (the S*F products, then p/q/t).
// Reset: rst_n clears all stage valid bits and done; payload is not reset.
// ---------------------------------------------------------------------------
// hsv_to_rgb_with_brightness_floor_core
// HSV to RGB conversion with value remapped to (brightness + 30) / 130,
// Q16 fixed point, channels rounded half up and saturated to 0..255.
// ---------------------------------------------------------------------------
module hsv_to_rgb_with_brightness_floor_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire hsvb_pkg::req_t request,
    output logic               busy,
    output logic               done,
    output hsvb_pkg::rsp_t     result
);

    localparam int unsigned QW     = hsvb_pkg::Q_W;
    localparam int unsigned FB     = hsvb_pkg::FRAC_BITS;
    localparam int unsigned SW     = hsvb_pkg::SECT_W;
    localparam int unsigned RW     = hsvb_pkg::REM_W;
    localparam int unsigned PROD_W = 2 * QW;
    localparam int unsigned ACC_W  = QW + hsvb_pkg::CHAN_W;
    localparam int unsigned CH_W   = ACC_W - FB;

    logic accept;

    // Stage 1: table reads, sector split, range check
    logic                 s1_valid_reg;
    hsvb_pkg::q17_t       s1_v_reg,      s1_v_next;
    hsvb_pkg::q17_t       s1_s_reg,      s1_s_next;
    logic [SW-1:0]        s1_sector_reg, s1_sector_next;
    logic [RW-1:0]        s1_rem_reg,    s1_rem_next;
    logic                 s1_ok_reg,     s1_ok_next;
    logic [SW+RW-1:0]     sector_deg;

    // Stage 2: hue fraction and its complement
    logic                 s2_valid_reg;
    hsvb_pkg::q17_t       s2_v_reg;
    hsvb_pkg::q17_t       s2_s_reg;
    hsvb_pkg::q17_t       s2_f_reg,  s2_f_next;
    hsvb_pkg::q17_t       s2_fc_reg, s2_fc_next;
    logic [SW-1:0]        s2_sector_reg;
    logic                 s2_ok_reg;

    // Stage 3: S*F and S*(1-F)
    logic                 s3_valid_reg;
    hsvb_pkg::q17_t       s3_v_reg;
    hsvb_pkg::q17_t       s3_s_reg;
    hsvb_pkg::q17_t       s3_sf_reg,  s3_sf_next;
    hsvb_pkg::q17_t       s3_sfc_reg, s3_sfc_next;
    logic [PROD_W-1:0]    prod_sf;
    logic [PROD_W-1:0]    prod_sfc;
    logic [SW-1:0]        s3_sector_reg;
    logic                 s3_ok_reg;

    // Stage 4: p, q, t
    logic                 s4_valid_reg;
    hsvb_pkg::q17_t       s4_v_reg;
    hsvb_pkg::q17_t       s4_p;
    hsvb_pkg::q17_t       s4_q;
    hsvb_pkg::q17_t       s4_t;
    logic [SW-1:0]        s4_sector_reg;
    logic                 s4_ok_reg;

    // Stage 5: permute and scale to channels
    hsvb_pkg::q17_t       sel_r, sel_g, sel_b;
    hsvb_pkg::rsp_t       rsp_reg, rsp_next;
    logic                 done_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Scale a Q16 value to 0..255, round half up, saturate
    function automatic logic [hsvb_pkg::CHAN_W-1:0] to_channel(input hsvb_pkg::q17_t x);
        logic [ACC_W-1:0] acc;
        logic [CH_W-1:0]  c;
        acc = (ACC_W'(x) << hsvb_pkg::CHAN_W) - ACC_W'(x) + ACC_W'(hsvb_pkg::HALF_Q);
        c   = acc[FB +: CH_W];
        return (c > CH_W'(hsvb_pkg::CHAN_MAX)) ? hsvb_pkg::CHAN_W'(hsvb_pkg::CHAN_MAX)
                                              : c[hsvb_pkg::CHAN_W-1:0];
    endfunction

    // Stage 1 logic: look up V and S, split hue, check ranges
    always_comb
    begin
        s1_v_next      = hsvb_pkg::V_LUT[request.brightness];
        s1_s_next      = hsvb_pkg::S_LUT[request.saturation];
        s1_sector_next = hsvb_pkg::hue_sector(request.hue);
        sector_deg     = (SW+RW)'(s1_sector_next) * (SW+RW)'(hsvb_pkg::SECTOR_DEG);
        s1_rem_next    = RW'(request.hue - hsvb_pkg::HUE_W'(sector_deg));
        s1_ok_next     = (request.brightness != '0)
                      && (request.brightness <= hsvb_pkg::PCT_W'(hsvb_pkg::PCT_FULL))
                      && (request.saturation <= hsvb_pkg::PCT_W'(hsvb_pkg::PCT_FULL))
                      && (request.hue < hsvb_pkg::HUE_W'(hsvb_pkg::HUE_LIMIT));
    end

    // Stage 2 logic: fraction of the sector
    always_comb
    begin
        s2_f_next  = QW'(hsvb_pkg::F_LUT[s1_rem_reg]);
        s2_fc_next = QW'(hsvb_pkg::ONE_Q - QW'(hsvb_pkg::F_LUT[s1_rem_reg]));
    end

    // Stage 3 logic: saturation times fraction
    always_comb
    begin
        prod_sf     = PROD_W'(s2_s_reg) * PROD_W'(s2_f_reg);
        prod_sfc    = PROD_W'(s2_s_reg) * PROD_W'(s2_fc_reg);
        s3_sf_next  = prod_sf[FB +: QW];
        s3_sfc_next = prod_sfc[FB +: QW];
    end

    // Stage 4: shade products
    hsvb_shade u_shade_p (.clk(clk), .v(s3_v_reg), .x(s3_s_reg),   .shade(s4_p));
    hsvb_shade u_shade_q (.clk(clk), .v(s3_v_reg), .x(s3_sf_reg),  .shade(s4_q));
    hsvb_shade u_shade_t (.clk(clk), .v(s3_v_reg), .x(s3_sfc_reg), .shade(s4_t));

    // Stage 5 logic: pick the channel order by sector, scale each channel
    always_comb
    begin
        case (s4_sector_reg)
            hsvb_pkg::SEC_RED_YEL:
            begin
                sel_r = s4_v_reg; sel_g = s4_t;     sel_b = s4_p;
            end
            hsvb_pkg::SEC_YEL_GRN:
            begin
                sel_r = s4_q;     sel_g = s4_v_reg; sel_b = s4_p;
            end
            hsvb_pkg::SEC_GRN_CYN:
            begin
                sel_r = s4_p;     sel_g = s4_v_reg; sel_b = s4_t;
            end
            hsvb_pkg::SEC_CYN_BLU:
            begin
                sel_r = s4_p;     sel_g = s4_q;     sel_b = s4_v_reg;
            end
            hsvb_pkg::SEC_BLU_MAG:
            begin
                sel_r = s4_t;     sel_g = s4_p;     sel_b = s4_v_reg;
            end
            default:
            begin
                sel_r = s4_v_reg; sel_g = s4_p;     sel_b = s4_q;
            end
        endcase
        rsp_next.red         = to_channel(sel_r);
        rsp_next.green       = to_channel(sel_g);
        rsp_next.blue        = to_channel(sel_b);
        rsp_next.color_valid = s4_ok_reg;
    end

    // Advance valid bits through the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    // Advance payload through the pipe
    always_ff @(posedge clk)
    begin
        s1_v_reg      <= s1_v_next;
        s1_s_reg      <= s1_s_next;
        s1_sector_reg <= s1_sector_next;
        s1_rem_reg    <= s1_rem_next;
        s1_ok_reg     <= s1_ok_next;

        s2_v_reg      <= s1_v_reg;
        s2_s_reg      <= s1_s_reg;
        s2_f_reg      <= s2_f_next;
        s2_fc_reg     <= s2_fc_next;
        s2_sector_reg <= s1_sector_reg;
        s2_ok_reg     <= s1_ok_reg;

        s3_v_reg      <= s2_v_reg;
        s3_s_reg      <= s2_s_reg;
        s3_sf_reg     <= s3_sf_next;
        s3_sfc_reg    <= s3_sfc_next;
        s3_sector_reg <= s2_sector_reg;
        s3_ok_reg     <= s2_ok_reg;

        s4_v_reg      <= s3_v_reg;
        s4_sector_reg <= s3_sector_reg;
        s4_ok_reg     <= s3_ok_reg;

        rsp_reg       <= rsp_next;
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule
`default_nettype wire

>>> sv/hsvb_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hsvb_checker
// Port-level checks for the HSV to RGB converter, bound to the top level.
// ---------------------------------------------------------------------------
module hsvb_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire hsvb_pkg::req_t request,
    input  wire logic          busy,
    input  wire logic          done,
    input  wire hsvb_pkg::rsp_t result
);

    localparam logic [hsvb_pkg::CHAN_W-1:0] MIN_PEAK = 8'd60;

    // Never refuse a request
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // One result per request, a fixed number of cycles later
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(start && !busy && rst_n, hsvb_pkg::LATENCY))
        else $error("result strobe does not match request timing");

    // Zero saturation gives a gray: all channels equal
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(start && !busy && rst_n && (request.saturation == '0),
                       hsvb_pkg::LATENCY))
        |-> (result.red == result.green) && (result.green == result.blue))
        else $error("zero saturation did not give a gray");

    // Brightness floor: a valid color always has a bright peak channel
    a_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.color_valid)
        |-> (result.red >= MIN_PEAK) || (result.green >= MIN_PEAK)
            || (result.blue >= MIN_PEAK))
        else $error("peak channel below brightness floor");

endmodule

bind hsv_to_rgb_with_brightness_floor_core hsvb_checker u_hsvb_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
);
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HSV to RGB converter with a brightness floor.
// Drives hue, saturation and brightness requests through start/busy,
// predicts each color in Q16 fixed point, and compares every done strobe
// against the oldest predicted color. Directed corner requests come first,
// then random requests with random idle bursts on the request side.
// ---------------------------------------------------------------------------
module tb_top;
    import hsvb_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_REQS    = 1000;
    localparam int unsigned CALM_TAIL      = 150;

    // -----------------------------------------------------------------------
    // Color predictor and queue of predicted colors
    // -----------------------------------------------------------------------
    class color_scoreboard;
        rsp_t pending_colors[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        // Product of two Q16 values, truncated
        function longint unsigned fx_mul(longint unsigned x, longint unsigned y);
            return (x * y) >> FRAC_BITS;
        endfunction

        // 1 - x, clamped at zero
        function longint unsigned clip_one_minus(longint unsigned x);
            longint unsigned one;
            one = longint'(1) << FRAC_BITS;
            return (x >= one) ? 0 : one - x;
        endfunction

        // Scale Q16 to 0..255, round half up, saturate
        function logic [CHAN_W-1:0] to_chan(longint unsigned x);
            longint unsigned c;
            c = (x * CHAN_MAX + HALF_Q) >> FRAC_BITS;
            if (c > CHAN_MAX)
            begin
                c = CHAN_MAX;
            end
            return CHAN_W'(c);
        endfunction

        function rsp_t expected_color(req_t r);
            longint unsigned   val, sat_q, frac, one, p, q, t, rr, gg, bb;
            logic [SECT_W-1:0] sector;
            rsp_t              e;
            one    = longint'(1) << FRAC_BITS;
            val    = ((longint'(r.brightness) + BRI_FLOOR) << FRAC_BITS) / BRI_SPAN;
            sat_q  = (longint'(r.saturation) << FRAC_BITS) / PCT_FULL;
            sector = SECT_W'(r.hue / SECTOR_DEG);
            frac   = (longint'(r.hue % SECTOR_DEG) << FRAC_BITS) / SECTOR_DEG;
            p = fx_mul(val, clip_one_minus(sat_q));
            q = fx_mul(val, clip_one_minus(fx_mul(sat_q, frac)));
            t = fx_mul(val, clip_one_minus(fx_mul(sat_q, one - frac)));
            // Permute by sector; sector 5 and the out-of-range ones share a slot
            case (sector)
                SEC_RED_YEL:
                begin
                    rr = val; gg = t;   bb = p;
                end
                SEC_YEL_GRN:
                begin
                    rr = q;   gg = val; bb = p;
                end
                SEC_GRN_CYN:
                begin
                    rr = p;   gg = val; bb = t;
                end
                SEC_CYN_BLU:
                begin
                    rr = p;   gg = q;   bb = val;
                end
                SEC_BLU_MAG:
                begin
                    rr = t;   gg = p;   bb = val;
                end
                default:
                begin
                    rr = val; gg = p;   bb = q;
                end
            endcase
            e.red         = to_chan(rr);
            e.green       = to_chan(gg);
            e.blue        = to_chan(bb);
            e.color_valid = (r.brightness >= 1) && (r.brightness <= PCT_FULL)
                         && (r.hue < HUE_LIMIT) && (r.saturation <= PCT_FULL);
            return e;
        endfunction

        function void note_request(req_t r);
            pending_colors.push_back(expected_color(r));
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp_c;
            if (pending_colors.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result r=%0d g=%0d b=%0d v=%0d", $time,
                         got.red, got.green, got.blue, got.color_valid);
                return;
            end
            exp_c = pending_colors.pop_front();
            if (got.red !== exp_c.red)
            begin
                errors++;
                $display("%0t: red expected %0d actual %0d", $time, exp_c.red, got.red);
            end
            if (got.green !== exp_c.green)
            begin
                errors++;
                $display("%0t: green expected %0d actual %0d", $time,
                         exp_c.green, got.green);
            end
            if (got.blue !== exp_c.blue)
            begin
                errors++;
                $display("%0t: blue expected %0d actual %0d", $time, exp_c.blue, got.blue);
            end
            if (got.color_valid !== exp_c.color_valid)
            begin
                errors++;
                $display("%0t: color_valid expected %0d actual %0d", $time,
                         exp_c.color_valid, got.color_valid);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    color_scoreboard sb = new();
    int unsigned     idle_cycles = 0;

    hsv_to_rgb_with_brightness_floor_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // Clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Note accepted requests and check strobed results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_request(request);
            end
            if (done)
            begin
                sb.check_result(result);
            end
        end
    end

    // Stop the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL hsv_to_rgb_with_brightness_floor_core");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Present one request and hold it until accepted
    task automatic send_hsv(input int unsigned h, input int unsigned s,
                            input int unsigned b);
        req_t r;
        r.hue        = HUE_W'(h);
        r.saturation = PCT_W'(s);
        r.brightness = PCT_W'(b);
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // Drop start for a burst of idle cycles
    task automatic idle_burst(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Random request: mostly in range, sometimes anywhere in the field
    task automatic send_random_hsv();
        int unsigned h, s, b;
        if ($urandom_range(0, 4) != 0)
        begin
            h = $urandom_range(0, HUE_LIMIT - 1);
            s = $urandom_range(0, PCT_FULL);
            b = $urandom_range(1, PCT_FULL);
            // Land on sector edges now and then
            if ($urandom_range(0, 7) == 0)
            begin
                h = SECTOR_DEG * $urandom_range(0, 5) + ($urandom_range(0, 1) ? 59 : 0);
            end
        end
        else
        begin
            h = $urandom_range(0, (1 << HUE_W) - 1);
            s = $urandom_range(0, (1 << PCT_W) - 1);
            b = $urandom_range(0, (1 << PCT_W) - 1);
        end
        send_hsv(h, s, b);
    endtask

    initial
    begin
        int unsigned drain;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: every sector, sector edges, hue past 359,
        // saturation above 100, brightness of 0 and above 100
        send_hsv(0,   100, 100);
        send_hsv(30,  100, 100);
        send_hsv(59,  100, 100);
        send_hsv(60,  100, 100);
        send_hsv(90,  50,  50);
        send_hsv(120, 100, 100);
        send_hsv(180, 100, 100);
        send_hsv(240, 100, 100);
        send_hsv(300, 100, 100);
        send_hsv(359, 100, 100);
        send_hsv(360, 100, 100);
        send_hsv(420, 80,  60);
        send_hsv(479, 100, 100);
        send_hsv(511, 127, 127);
        send_hsv(0,   0,   0);
        send_hsv(200, 0,   1);
        send_hsv(100, 101, 50);
        send_hsv(150, 127, 100);
        send_hsv(250, 50,  101);
        send_hsv(330, 100, 127);
        send_hsv(45,  0,   100);
        send_hsv(511, 0,   0);
        send_hsv(200, 100, 1);
        idle_burst(3);

        // Random requests, idle bursts except in the tail
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            send_random_hsv();
            if (i < RANDOM_REQS - CALM_TAIL && $urandom_range(0, 3) == 0)
            begin
                idle_burst($urandom_range(1, 12));
            end
        end
        start <= 1'b0;

        // Drain outstanding colors, then let the pipeline settle
        while (sb.pending_colors.size() != 0)
        begin
            @(posedge clk);
        end
        drain = LATENCY * 4;
        repeat (drain) @(posedge clk);

        if (sb.errors == 0 && sb.pending_colors.size() == 0)
        begin
            $display("PASS hsv_to_rgb_with_brightness_floor_core");
        end
        else
        begin
            $display("FAIL hsv_to_rgb_with_brightness_floor_core");
        end
        $finish;
    end

endmodule
